// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dft2d_pkg.sv -----
// ----------------------------------------------------------------------------
// dft2d_pkg
// Shared types and constants of the direct 2D DFT block.
// ----------------------------------------------------------------------------
package dft2d_pkg;

    // Item field widths
    localparam int IDX_W       = 5;
    localparam int SMP_IN_W    = 16;
    localparam int COEF_W      = 27;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // Saturation limits of a coefficient
    localparam int COEF_POS_MAX = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_NEG_MAG = 1 << (COEF_W - 1);

    // Item kinds carried on tuser
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor term divisors: sin 2n(2n+1), cos (2n-1)2n, n = 1..10
    localparam longint unsigned SIN_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };
    localparam longint unsigned COS_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_HOLD
    } seq_state_t;

endpackage

// ----- rtl/dft2d_div.sv -----
// ----------------------------------------------------------------------------
// dft2d_div
// Rounding shifter: divides by a power of two (forward or inverse scale),
// rounds half away from zero and saturates to the signed coefficient range.
// Three register stages: magnitude, rounded shift, saturate and sign.
// ----------------------------------------------------------------------------
module dft2d_div
    import dft2d_pkg::*;
#(
    parameter int ACC_W     = 43,
    parameter int SHIFT_FWD = 15,
    parameter int SHIFT_INV = 25
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  dividend,
    input  logic                     inverse,
    output logic                     done,
    output logic signed [COEF_W-1:0] quotient
);

    localparam int QW = ACC_W + 1;
    localparam int EW = (QW > COEF_W + 1) ? QW : COEF_W + 1;

    logic                     mag_vld_reg;
    logic                     rnd_vld_reg;
    logic                     done_reg;
    logic                     mag_neg_reg;
    logic                     rnd_neg_reg;
    logic                     inv_reg;
    logic [ACC_W-1:0]         mag_reg;
    logic [QW-1:0]            q_rnd_reg;
    logic signed [COEF_W-1:0] quotient_reg;

    logic [ACC_W-1:0]  mag;
    logic [QW-1:0]     sum_fwd;
    logic [QW-1:0]     sum_inv;
    logic [QW-1:0]     q_rnd;
    logic [EW-1:0]     q_ext;
    logic [COEF_W-1:0] q_sat;
    logic [COEF_W-1:0] q_res;

    assign mag = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;

    // Add half the divisor, then shift the magnitude
    assign sum_fwd = {1'b0, mag_reg} + (QW'(1) << (SHIFT_FWD - 1));
    assign sum_inv = {1'b0, mag_reg} + (QW'(1) << (SHIFT_INV - 1));
    assign q_rnd   = inv_reg ? (sum_inv >> SHIFT_INV) : (sum_fwd >> SHIFT_FWD);
    assign q_ext   = EW'(q_rnd_reg);

    always_comb
    begin
        if (rnd_neg_reg)
        begin
            if (q_ext > EW'(COEF_NEG_MAG))
                q_sat = COEF_W'(COEF_NEG_MAG);
            else
                q_sat = q_ext[COEF_W-1:0];
        end
        else
        begin
            if (q_ext > EW'(COEF_POS_MAX))
                q_sat = COEF_W'(COEF_POS_MAX);
            else
                q_sat = q_ext[COEF_W-1:0];
        end
        q_res = rnd_neg_reg ? (~q_sat + 1'b1) : q_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mag_vld_reg <= start;
            rnd_vld_reg <= mag_vld_reg;
            done_reg    <= rnd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_neg_reg <= dividend[ACC_W-1];
            mag_reg     <= mag;
            inv_reg     <= inverse;
        end
        if (mag_vld_reg)
        begin
            rnd_neg_reg <= mag_neg_reg;
            q_rnd_reg   <= q_rnd;
        end
        if (rnd_vld_reg)
            quotient_reg <= q_res;
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

// ----- rtl/dft_2d_direct.sv -----
// ----------------------------------------------------------------------------
// dft_2d_direct
// Direct 2D DFT over a stored W x H complex sample array, one complex
// multiply-accumulate per stored sample, twiddles from a quarter-wave ROM.
// ----------------------------------------------------------------------------
//  channel | signals                              | moves
//  --------+--------------------------------------+------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser    | load or compute item
//  out     | m_tvalid m_tready m_tdata            | one coefficient per compute
//  cfg     | cfg_wr_en cfg_wr_data                | inverse_mode register
//
//  A load item gives no result.
//  A compute runs frequency reduction, the sweep (one sample per cycle
//  through the MAC), pipeline drain, the shared rounding shifter for each
//  part (real, then imaginary) and the load of the output register, which
//  waits while the last result is not yet taken; s_tready is low meanwhile.
//  W*H must be a power of two: the inverse scale is a rounding shift.
//  The output register frees the input side once the result is stored.
//  Reset clears control state only; the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dft_2d_direct
    import dft2d_pkg::*;
#(
    parameter int WIDTH_POINTS  = 32,
    parameter int HEIGHT_POINTS = 32,
    parameter int SAMPLE_BITS   = 16,
    parameter int TWIDDLE_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // row_index[4:0], col_index[9:5], sample_real[25:10], sample_imag[41:26]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // coef_real[26:0], coef_imag[53:27]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data
);

    localparam int NPTS      = WIDTH_POINTS * HEIGHT_POINTS;
    localparam int KW        = $clog2(NPTS);
    localparam int JW        = $clog2(HEIGHT_POINTS);
    localparam int PW        = SAMPLE_BITS + TWIDDLE_BITS;
    localparam int ACC_W     = PW + KW + 1;
    localparam int SHIFT_FWD = TWIDDLE_BITS - 1;
    localparam int SHIFT_INV = TWIDDLE_BITS - 1 + KW;

    typedef logic [2*TWIDDLE_BITS-1:0] rom_t [NPTS];

    // ------------------------------------------------------------------
    // Twiddle ROM, built at elaboration: entry r holds {sin, cos} of
    // r*(pi/2)/N, rounded to Q1.(TWIDDLE_BITS-1)
    // ------------------------------------------------------------------
    function automatic logic [TWIDDLE_BITS-1:0] tw_round(input longint v);
        longint unsigned m;
        longint unsigned mx;
        logic            neg;
        neg = v < 0;
        m   = neg ? longint'(-v) : v;
        mx  = (64'd1 << (TWIDDLE_BITS - 1)) - 64'd1;
        m   = (m + (64'd1 << (30 - TWIDDLE_BITS))) >> (31 - TWIDDLE_BITS);
        if (m > mx)
            m = mx;
        return neg ? TWIDDLE_BITS'(~m + 64'd1) : TWIDDLE_BITS'(m);
    endfunction

    function automatic rom_t build_rom();
        rom_t              t;
        longint unsigned   a;
        longint unsigned   a2;
        longint unsigned   ts;
        longint unsigned   tc;
        longint            s_sum;
        longint            c_sum;
        for (int r = 0; r < NPTS; r++)
        begin
            a     = (longint'(r) * HALF_PI_Q30) / NPTS;
            a2    = (a * a) >> 30;
            ts    = a;
            tc    = 64'd1 << 30;
            s_sum = longint'(ts);
            c_sum = longint'(tc);
            for (int n = 1; n <= 10; n++)
            begin
                ts = ((ts * a2) >> 30) / SIN_DIV[n-1];
                tc = ((tc * a2) >> 30) / COS_DIV[n-1];
                if (n[0])
                begin
                    s_sum = s_sum - longint'(ts);
                    c_sum = c_sum - longint'(tc);
                end
                else
                begin
                    s_sum = s_sum + longint'(ts);
                    c_sum = c_sum + longint'(tc);
                end
            end
            t[r] = {tw_round(s_sum), tw_round(c_sum)};
        end
        return t;
    endfunction

    localparam rom_t TW_ROM = build_rom();

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
        input logic signed [SMP_IN_W-1:0] x
    );
        int v;
        int hi;
        v  = int'(x);
        hi = (1 << (SAMPLE_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [KW-1:0] mod_add(input logic [KW-1:0] a,
                                              input logic [KW-1:0] b);
        logic [KW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (KW+1)'(NPTS))
            sum = sum - (KW+1)'(NPTS);
        return sum[KW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]           in_row;
    logic [IDX_W-1:0]           in_col;
    logic signed [SMP_IN_W-1:0] in_re;
    logic signed [SMP_IN_W-1:0] in_im;
    logic                       in_acc;

    assign in_row = s_tdata[4:0];
    assign in_col = s_tdata[9:5];
    assign in_re  = s_tdata[25:10];
    assign in_im  = s_tdata[41:26];
    assign in_acc = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;
    logic       inv_mode_reg;

    logic [IDX_W-1:0] u_reg;
    logic [IDX_W-1:0] v_reg;
    logic [KW-1:0]    du_reg;
    logic [KW-1:0]    dv_reg;
    logic [KW-1:0]    e_reg;
    logic [JW-1:0]    j_reg;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    base_reg;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic [2*SAMPLE_BITS-1:0] smp1_reg;
    logic [2*SAMPLE_BITS-1:0] smp2_reg;
    quad_t                    q1_reg;
    quad_t                    q2_reg;
    logic [KW-1:0]            r1_reg;
    logic [2*TWIDDLE_BITS-1:0] tw_reg;

    logic signed [PW-1:0]    prr_reg;
    logic signed [PW-1:0]    pis_reg;
    logic signed [PW-1:0]    pic_reg;
    logic signed [PW-1:0]    prs_reg;
    logic signed [ACC_W-1:0] acc_re_reg;
    logic signed [ACC_W-1:0] acc_im_reg;

    logic signed [COEF_W-1:0] coef_re_reg;
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic [2*SAMPLE_BITS-1:0] mem [NPTS];

    // ------------------------------------------------------------------
    // Sample store: row-major, entry i*H + j
    // ------------------------------------------------------------------
    logic          ld_we;
    logic [KW-1:0] ld_addr;

    assign ld_we = in_acc && (s_tuser == FUNC_LOAD) &&
                   (int'(in_row) < WIDTH_POINTS) && (int'(in_col) < HEIGHT_POINTS);
    assign ld_addr = KW'(int'(in_row) * HEIGHT_POINTS + int'(in_col));

    always_ff @(posedge clk)
    begin
        if (ld_we)
            mem[ld_addr] <= {clamp_sample(in_im), clamp_sample(in_re)};
    end

    always_ff @(posedge clk)
    begin
        smp1_reg <= mem[e_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            inv_mode_reg <= cfg_wr_data;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic u_fit;
    logic v_fit;
    logic j_last;
    logic e_last;
    logic pipe_busy;
    logic div_start;
    logic div_sel_im;
    logic div_done;
    logic out_load;
    logic signed [COEF_W-1:0] div_q;

    assign u_fit     = int'(u_reg) < WIDTH_POINTS;
    assign v_fit     = int'(v_reg) < HEIGHT_POINTS;
    assign j_last    = j_reg == JW'(HEIGHT_POINTS - 1);
    assign e_last    = e_reg == KW'(NPTS - 1);
    assign pipe_busy = v1_reg || v2_reg || v3_reg;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_sel_im = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && s_tuser == FUNC_COMPUTE)
                    state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (u_fit && v_fit)
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (e_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_RE;
                end
            end
            ST_DIV_RE:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_sel_im = 1'b1;
                    state_next = ST_DIV_IM;
                end
            end
            ST_DIV_IM:
            begin
                if (div_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_SWEEP);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    // Frequency reduction and sweep counters
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                u_reg <= in_row;
                v_reg <= in_col;
            end
            ST_REDUCE:
            begin
                // fold u into 0..W-1 and v into 0..H-1
                if (!u_fit)
                    u_reg <= u_reg - IDX_W'(WIDTH_POINTS);
                if (!v_fit)
                    v_reg <= v_reg - IDX_W'(HEIGHT_POINTS);
                du_reg   <= KW'(int'(u_reg) * HEIGHT_POINTS);
                dv_reg   <= KW'(int'(v_reg) * WIDTH_POINTS);
                e_reg    <= '0;
                j_reg    <= '0;
                k_reg    <= '0;
                base_reg <= '0;
            end
            ST_SWEEP:
            begin
                e_reg <= e_reg + 1'b1;
                if (j_last)
                begin
                    j_reg    <= '0;
                    base_reg <= mod_add(base_reg, du_reg);
                    k_reg    <= mod_add(base_reg, du_reg);
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                    k_reg <= mod_add(k_reg, dv_reg);
                end
            end
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // MAC pipeline: quadrant split, ROM read, products, accumulate
    // ------------------------------------------------------------------
    logic [KW+1:0] p4;
    quad_t         q_c;
    logic [KW+1:0] r_c;

    assign p4 = {k_reg, 2'b00};

    always_comb
    begin
        if (p4 >= (KW+2)'(3 * NPTS))
        begin
            q_c = QUAD_3;
            r_c = p4 - (KW+2)'(3 * NPTS);
        end
        else if (p4 >= (KW+2)'(2 * NPTS))
        begin
            q_c = QUAD_2;
            r_c = p4 - (KW+2)'(2 * NPTS);
        end
        else if (p4 >= (KW+2)'(NPTS))
        begin
            q_c = QUAD_1;
            r_c = p4 - (KW+2)'(NPTS);
        end
        else
        begin
            q_c = QUAD_0;
            r_c = p4;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg   <= q_c;
        r1_reg   <= r_c[KW-1:0];
        tw_reg   <= TW_ROM[r1_reg];
        q2_reg   <= q1_reg;
        smp2_reg <= smp1_reg;
    end

    logic signed [TWIDDLE_BITS-1:0] c_rom;
    logic signed [TWIDDLE_BITS-1:0] s_rom;
    logic signed [TWIDDLE_BITS-1:0] c_q;
    logic signed [TWIDDLE_BITS-1:0] s_q;
    logic signed [TWIDDLE_BITS-1:0] s_eff;
    logic signed [SAMPLE_BITS-1:0]  re_s;
    logic signed [SAMPLE_BITS-1:0]  im_eff;

    assign c_rom = tw_reg[TWIDDLE_BITS-1:0];
    assign s_rom = tw_reg[2*TWIDDLE_BITS-1:TWIDDLE_BITS];

    always_comb
    begin
        case (q2_reg)
            QUAD_0:
            begin
                c_q = c_rom;
                s_q = s_rom;
            end
            QUAD_1:
            begin
                c_q = -s_rom;
                s_q = c_rom;
            end
            QUAD_2:
            begin
                c_q = -c_rom;
                s_q = -s_rom;
            end
            QUAD_3:
            begin
                c_q = s_rom;
                s_q = -c_rom;
            end
            default:
            begin
                c_q = c_rom;
                s_q = s_rom;
            end
        endcase
    end

    // Forward: drop the imaginary part and flip the sine
    assign re_s   = smp2_reg[SAMPLE_BITS-1:0];
    assign im_eff = inv_mode_reg ? smp2_reg[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign s_eff  = inv_mode_reg ? s_q : -s_q;

    always_ff @(posedge clk)
    begin
        prr_reg <= re_s * c_q;
        pis_reg <= im_eff * s_eff;
        pic_reg <= im_eff * c_q;
        prs_reg <= re_s * s_eff;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_REDUCE)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prr_reg) - ACC_W'(pis_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(pic_reg) + ACC_W'(prs_reg);
        end
    end

    // ------------------------------------------------------------------
    // Scaling through the shared rounding shifter
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] div_dividend;

    assign div_dividend = div_sel_im ? acc_im_reg : acc_re_reg;

    dft2d_div #(
        .ACC_W     (ACC_W),
        .SHIFT_FWD (SHIFT_FWD),
        .SHIFT_INV (SHIFT_INV)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .inverse  (inv_mode_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV_RE && div_done)
            coef_re_reg <= div_q;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {(OUT_TDATA_W - 2*COEF_W)'(0), div_q, coef_re_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_busy_no_accept, pipe_busy, !s_tready, "item accepted while MAC busy")
    `ASSERT_NEXT(a_sweep_exit, state_reg == ST_SWEEP, state_reg == ST_SWEEP || state_reg == ST_DRAIN, "sweep left early")
    `ASSERT_IMPLIES(a_out_from_hold, $rose(m_tvalid_reg), $past(state_reg) == ST_HOLD, "result without compute")

endmodule
